// ===== rtl/rgcd_seg_pkg.sv =====
// ----------------------------------------------------------------------------
// Range GCD segment tree package
// Opcodes and stream field layout shared by the range GCD segment tree.
// ----------------------------------------------------------------------------
package rgcd_seg_pkg;

	// Request kinds carried on s_tuser.
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Input request field widths.
	localparam int POSITION_W = 8;
	localparam int VALUE_W    = 32;
	localparam int RANGE_W    = 9;

	// Input tdata layout, lowest field first.
	localparam int POSITION_LSB = 0;
	localparam int VALUE_LSB    = POSITION_LSB + POSITION_W;
	localparam int BEGIN_LSB    = VALUE_LSB + VALUE_W;
	localparam int END_LSB      = BEGIN_LSB + RANGE_W;
	localparam int S_FIELDS_W   = END_LSB + RANGE_W;
	localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

	// Output tdata holds only the result.
	localparam int M_TDATA_W = 32;

endpackage

// ===== rtl/range_gcd_segment_tree_top.sv =====
// ----------------------------------------------------------------------------
// Range GCD segment tree
// Bottom-up segment tree of unsigned values answering range gcd queries
// with one shared binary gcd unit and a tree memory with separate write and read ports.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream. s_tuser selects the kind: an update
// writes value at leaf position and recomputes every ancestor; a query
// returns gcd over leaves [range_begin, range_end) on the m_ stream.
// Updates produce no result. An empty or reversed range returns 0, and an
// update beyond the leaves is dropped.
// After reset the tree memory is cleared one node a cycle; s_tready stays
// low until that pass ends.
// One request is processed at a time. Every node visit costs one memory
// read plus one gcd on the shared binary gcd unit, followed by the shift
// back. An update visits log2(LEAVES) levels, a query at most
// 2*log2(LEAVES) nodes.
// The result sits in an output register; a new request is accepted while
// it waits, and only a second query result stalls until m_tready.
// ----------------------------------------------------------------------------
module range_gcd_segment_tree_top #(
	parameter int LEAVES     = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: position[7:0], value[39:8], range_begin[48:40], range_end[57:49]
	input  logic [rgcd_seg_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: opcode[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: gcd_result[31:0]
	output logic [rgcd_seg_pkg::M_TDATA_W-1:0] m_tdata
);
	import rgcd_seg_pkg::*;

	localparam int NODES = 2 * LEAVES;
	localparam int AW    = $clog2(NODES);
	localparam int IW    = AW + 1;
	localparam int KW    = $clog2(VALUE_BITS + 1);
	localparam logic [31:0] LEAVES_W = 32'(LEAVES);
	localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
	localparam logic [AW-1:0] ROOT_NODE = AW'(1);

	// Sequencer states.
	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_U_LEVEL = 4'd2;
	localparam logic [3:0] ST_RD_WAIT = 4'd3;
	localparam logic [3:0] ST_LOAD    = 4'd4;
	localparam logic [3:0] ST_GCD     = 4'd5;
	localparam logic [3:0] ST_UNSHIFT = 4'd6;
	localparam logic [3:0] ST_Q_CHECK = 4'd7;
	localparam logic [3:0] ST_Q_HI    = 4'd8;
	localparam logic [3:0] ST_Q_SHIFT = 4'd9;

	logic [3:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic                  op_q;
	logic                  qphase_q;
	logic [AW-1:0]         idx_q;
	logic [IW-1:0]         lo_q;
	logic [IW-1:0]         hi_q;
	logic [AW-1:0]         rd_addr_q;
	logic [VALUE_BITS-1:0] rd_data_q;
	logic [VALUE_BITS-1:0] a_q;
	logic [VALUE_BITS-1:0] b_q;
	logic [KW-1:0]         k_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	logic [VALUE_BITS-1:0] tree_mem [NODES];

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_data;

	// Request field decode.
	logic                  s_fire;
	logic [31:0]           pos_w;
	logic [31:0]           beg_w;
	logic [31:0]           end_w;
	logic [31:0]           beg_sat;
	logic [31:0]           end_sat;
	logic                  pos_ok;
	logic [AW-1:0]         leaf_idx;
	logic [VALUE_BITS-1:0] val_masked;

	assign s_fire     = s_tvalid && s_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign pos_w      = 32'(s_tdata[POSITION_LSB +: POSITION_W]);
	assign beg_w      = 32'(s_tdata[BEGIN_LSB +: RANGE_W]);
	assign end_w      = 32'(s_tdata[END_LSB +: RANGE_W]);
	assign beg_sat    = (beg_w > LEAVES_W) ? LEAVES_W : beg_w;
	assign end_sat    = (end_w > LEAVES_W) ? LEAVES_W : end_w;
	assign pos_ok     = (pos_w < LEAVES_W);
	assign leaf_idx   = AW'(pos_w + LEAVES_W);
	assign val_masked = VALUE_BITS'(s_tdata[VALUE_LSB +: VALUE_W]);

	// Binary gcd step operands.
	logic                  a_zero;
	logic                  b_zero;
	logic [VALUE_BITS:0]   diff_ab;
	logic [VALUE_BITS-1:0] diff_ba;
	logic                  a_ge_b;

	assign a_zero  = (a_q == '0);
	assign b_zero  = (b_q == '0);
	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = b_q - a_q;
	assign a_ge_b  = !diff_ab[VALUE_BITS];

	logic unshift_done;
	assign unshift_done = (state_q == ST_UNSHIFT) && (k_q == '0);

	// A finished query moves its result into a free or draining output register.
	logic out_load;
	assign out_load = (state_q == ST_Q_CHECK) && !(lo_q < hi_q) && (!m_tvalid_q || m_tready);

	// Memory write port selection: clearing pass, leaf write, ancestor write.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == ST_IDLE && s_fire && s_tuser == OP_UPDATE && pos_ok) begin
			wr_en   = 1'b1;
			wr_addr = leaf_idx;
			wr_data = val_masked;
		end else if (unshift_done && op_q == OP_UPDATE) begin
			wr_en   = 1'b1;
			wr_addr = idx_q >> 1;
			wr_data = a_q;
		end
	end

	// Tree memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tree_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= tree_mem[rd_addr_q];
	end

	// Output register: load a finished query result, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= M_TDATA_W'(a_q);
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Sequencer and gcd unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			op_q       <= OP_UPDATE;
			qphase_q   <= 1'b0;
			idx_q      <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			rd_addr_q  <= '0;
			a_q        <= '0;
			b_q        <= '0;
			k_q        <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_fire) begin
						op_q <= s_tuser;
						if (s_tuser == OP_UPDATE) begin
							a_q   <= val_masked;
							idx_q <= leaf_idx;
							if (pos_ok) begin
								state_q <= ST_U_LEVEL;
							end
						end else begin
							a_q  <= '0;
							lo_q <= IW'(beg_sat + LEAVES_W);
							hi_q <= IW'(end_sat + LEAVES_W);
							state_q <= ST_Q_CHECK;
						end
					end
				end
				// Update: combine the current node with its sibling into the parent.
				ST_U_LEVEL: begin
					if (idx_q == ROOT_NODE) begin
						state_q <= ST_IDLE;
					end else begin
						rd_addr_q <= idx_q ^ AW'(1);
						state_q   <= ST_RD_WAIT;
					end
				end
				ST_RD_WAIT: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					b_q     <= rd_data_q;
					k_q     <= '0;
					state_q <= ST_GCD;
				end
				// One binary gcd step per cycle; the result ends in a_q.
				ST_GCD: begin
					if (a_zero) begin
						a_q     <= b_q;
						state_q <= ST_UNSHIFT;
					end else if (b_zero) begin
						state_q <= ST_UNSHIFT;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + KW'(1);
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_ge_b) begin
						a_q <= diff_ab[VALUE_BITS:1];
					end else begin
						b_q <= diff_ba >> 1;
					end
				end
				// Restore the common power of two, then return to the caller.
				ST_UNSHIFT: begin
					if (k_q != '0) begin
						a_q <= a_q << 1;
						k_q <= k_q - KW'(1);
					end else if (op_q == OP_UPDATE) begin
						idx_q   <= idx_q >> 1;
						state_q <= ST_U_LEVEL;
					end else if (!qphase_q) begin
						lo_q    <= lo_q + IW'(1);
						state_q <= ST_Q_HI;
					end else begin
						state_q <= ST_Q_SHIFT;
					end
				end
				// Query: left boundary node, or finish when the bounds meet or cross.
				ST_Q_CHECK: begin
					if (lo_q < hi_q) begin
						if (lo_q[0]) begin
							rd_addr_q <= AW'(lo_q);
							qphase_q  <= 1'b0;
							state_q   <= ST_RD_WAIT;
						end else begin
							state_q <= ST_Q_HI;
						end
					end else if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				// Query: right boundary node.
				ST_Q_HI: begin
					if (hi_q[0]) begin
						hi_q      <= hi_q - IW'(1);
						rd_addr_q <= AW'(hi_q - IW'(1));
						qphase_q  <= 1'b1;
						state_q   <= ST_RD_WAIT;
					end else begin
						state_q <= ST_Q_SHIFT;
					end
				end
				ST_Q_SHIFT: begin
					lo_q    <= lo_q >> 1;
					hi_q    <= hi_q >> 1;
					state_q <= ST_Q_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range GCD segment tree testbench
// Drives updates and range gcd queries into the segment tree, keeps a shadow
// copy of the tree to predict query results not fixed by a directed row, and
// compares each result leaving the block against the oldest expected gcd. A short
// table of directed requests comes first, then random ones with shared factors.
// ----------------------------------------------------------------------------
module testbench;
	import rgcd_seg_pkg::*;

	localparam int LEAF_COUNT    = 256;
	localparam int RANDOM_COUNT  = 1500;
	localparam int GAP_MAX       = 18;
	localparam int LONG_HOLD     = 1500;
	localparam int DRAIN_CYCLES  = 2000;
	localparam int CYCLE_LIMIT   = 10_000_000;
	localparam int REPORT_LIMIT  = 50;

	// One row of the directed request table.
	typedef struct packed {
		logic        opcode;
		logic [7:0]  position;
		logic [31:0] value;
		logic [8:0]  range_begin;
		logic [8:0]  range_end;
		logic        has_fixed;
		logic [31:0] fixed_gcd;
	} request_row_t;

	localparam int DIRECTED_COUNT = 23;
	localparam request_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// Cleared tree answers zero everywhere.
		'{OP_QUERY,  8'd0,   32'd0,          9'd0,   9'd256, 1'b1, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd0,   9'd0,   1'b1, 32'd0},
		// Largest value at the lowest leaf.
		'{OP_UPDATE, 8'd0,   32'hFFFF_FFFF,  9'd0,   9'd0,   1'b0, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd0,   9'd1,   1'b1, 32'hFFFF_FFFF},
		'{OP_QUERY,  8'd0,   32'd0,          9'd1,   9'd256, 1'b1, 32'd0},
		// Highest leaf, with range fields that an update ignores.
		'{OP_UPDATE, 8'd255, 32'd12,         9'h1FF, 9'h155, 1'b0, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd255, 9'd256, 1'b1, 32'd12},
		'{OP_QUERY,  8'd0,   32'd0,          9'd0,   9'd256, 1'b0, 32'd0},
		// Both bounds beyond the leaves saturate to an empty range.
		'{OP_QUERY,  8'd0,   32'd0,          9'd300, 9'd511, 1'b1, 32'd0},
		// Reversed and empty ranges.
		'{OP_QUERY,  8'd0,   32'd0,          9'd10,  9'd5,   1'b1, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd256, 9'd256, 1'b1, 32'd0},
		// Only the end saturates.
		'{OP_QUERY,  8'd0,   32'd0,          9'd200, 9'd511, 1'b0, 32'd0},
		'{OP_UPDATE, 8'd128, 32'd0,          9'd0,   9'd0,   1'b0, 32'd0},
		'{OP_UPDATE, 8'd1,   32'h8000_0000,  9'd0,   9'd0,   1'b0, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd0,   9'd2,   1'b0, 32'd0},
		'{OP_UPDATE, 8'd254, 32'd18,         9'h0AA, 9'h123, 1'b0, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd254, 9'd256, 1'b0, 32'd0},
		// A query ignores its position and value fields.
		'{OP_QUERY,  8'hAA,  32'h5555_5555,  9'd1,   9'd255, 1'b0, 32'd0},
		'{OP_UPDATE, 8'd0,   32'd0,          9'd0,   9'd0,   1'b0, 32'd0},
		'{OP_UPDATE, 8'd127, 32'd1,          9'd0,   9'd0,   1'b0, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd0,   9'd256, 1'b0, 32'd0},
		'{OP_QUERY,  8'd0,   32'd0,          9'd128, 9'd129, 1'b1, 32'd0},
		// Begin beyond the leaves, end further out.
		'{OP_QUERY,  8'd0,   32'd0,          9'd257, 9'd300, 1'b1, 32'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = OP_UPDATE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Shadow copy of the tree and the gcds still owed by the block.
	logic [31:0] tree_mirror [0:2*LEAF_COUNT-1];
	logic [31:0] pending_gcds [$];
	logic [31:0] oldest_gcd;

	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned updates_sent = 0;
	int unsigned queries_sent = 0;
	longint unsigned cycle_count = 0;
	bit          sender_steady = 1'b0;
	bit          receiver_steady = 1'b0;
	bit          long_hold_done = 1'b0;

	range_gcd_segment_tree_top #(
		.LEAVES     (LEAF_COUNT),
		.VALUE_BITS (32)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Euclid's algorithm; gcd(x, 0) = x keeps zero as the identity.
	function automatic logic [31:0] gcd32(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		while (b != 32'd0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// Write one leaf and rebuild its ancestors up to the root.
	function automatic void apply_update(input logic [7:0] position, input logic [31:0] value);
		int node;
		node = LEAF_COUNT + position;
		tree_mirror[node] = value;
		node = node >> 1;
		while (node != 0) begin
			tree_mirror[node] = gcd32(tree_mirror[2*node], tree_mirror[2*node+1]);
			node = node >> 1;
		end
	endfunction

	// Bottom-up range gcd over [range_begin, range_end), bounds saturated.
	function automatic logic [31:0] range_gcd_of(input logic [8:0] range_begin,
			input logic [8:0] range_end);
		int lo;
		int hi;
		logic [31:0] left_acc;
		logic [31:0] right_acc;
		lo = (range_begin > LEAF_COUNT) ? LEAF_COUNT : range_begin;
		hi = (range_end > LEAF_COUNT) ? LEAF_COUNT : range_end;
		left_acc = '0;
		right_acc = '0;
		if (lo >= hi)
			return '0;
		lo += LEAF_COUNT;
		hi += LEAF_COUNT;
		while (lo < hi) begin
			if (lo[0]) begin
				left_acc = gcd32(left_acc, tree_mirror[lo]);
				lo++;
			end
			if (hi[0]) begin
				hi--;
				right_acc = gcd32(tree_mirror[hi], right_acc);
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return gcd32(left_acc, right_acc);
	endfunction

	function automatic logic [S_TDATA_W-1:0] pack_fields(input logic [7:0] position,
			input logic [31:0] value, input logic [8:0] range_begin,
			input logic [8:0] range_end);
		logic [S_TDATA_W-1:0] data;
		data = '0;
		data[POSITION_LSB +: POSITION_W] = position;
		data[VALUE_LSB +: VALUE_W] = value;
		data[BEGIN_LSB +: RANGE_W] = range_begin;
		data[END_LSB +: RANGE_W] = range_end;
		return data;
	endfunction

	// Leaf value: mostly multiples of the current shared factor, plus edge values.
	function automatic logic [31:0] pick_value(input logic [31:0] factor);
		int unsigned pick;
		logic [63:0] product;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return '0;
		if (pick < 13)
			return '1;
		if (pick < 20)
			return $urandom;
		if (pick < 25)
			return 32'd1 << $urandom_range(0, 31);
		product = factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
		return product[31:0];
	endfunction

	function automatic logic [31:0] pick_factor();
		case ($urandom_range(0, 7))
			0: return 32'd1;
			1: return 32'd6;
			2: return 32'd91;
			3: return 32'd256;
			4: return 32'd1 << 20;
			5: return 32'd255;
			6: return 32'd65537;
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	// Offer one request after a random gap, none while the sender is steady, and record it once accepted.
	task automatic send_request(input logic opcode, input logic [7:0] position,
			input logic [31:0] value, input logic [8:0] range_begin,
			input logic [8:0] range_end, input logic has_fixed, input logic [31:0] fixed_gcd);
		int unsigned gap;
		gap = sender_steady ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= opcode;
		s_tdata <= pack_fields(position, value, range_begin, range_end);
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		if (opcode == OP_UPDATE) begin
			apply_update(position, value);
			updates_sent++;
		end else begin
			pending_gcds.insert(pending_gcds.size(),
				has_fixed ? fixed_gcd : range_gcd_of(range_begin, range_end));
			queries_sent++;
		end
	endtask

	// Request generator: directed table, then random requests.
	initial begin
		logic [31:0] factor;
		logic [7:0]  position;
		logic [8:0]  range_begin;
		logic [8:0]  range_end;
		logic [8:0]  span_a;
		logic [8:0]  span_b;
		int unsigned pick;

		for (int n = 0; n < 2*LEAF_COUNT; n++)
			tree_mirror[n] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_COUNT; r++)
			send_request(DIRECTED_ROWS[r].opcode, DIRECTED_ROWS[r].position,
				DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].range_begin,
				DIRECTED_ROWS[r].range_end, DIRECTED_ROWS[r].has_fixed,
				DIRECTED_ROWS[r].fixed_gcd);

		factor = pick_factor();
		for (int k = 0; k < RANDOM_COUNT; k++) begin
			if (k % 80 == 0)
				factor = pick_factor();
			if (k % 64 == 0)
				sender_steady = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 99) < 45) begin
				// Update: mostly anywhere, sometimes crowded at either end.
				pick = $urandom_range(0, 9);
				if (pick == 0)
					position = 8'($urandom_range(0, 7));
				else if (pick == 1)
					position = 8'($urandom_range(248, 255));
				else
					position = 8'($urandom);
				send_request(OP_UPDATE, position, pick_value(factor), 9'($urandom),
					9'($urandom), 1'b0, '0);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					span_a = 9'($urandom_range(0, LEAF_COUNT));
					span_b = 9'($urandom_range(0, LEAF_COUNT));
					range_begin = (span_a < span_b) ? span_a : span_b;
					range_end = (span_a < span_b) ? span_b : span_a;
				end else if (pick < 65) begin
					range_begin = 9'($urandom_range(0, LEAF_COUNT - 1));
					range_end = 9'(range_begin + $urandom_range(1, 8));
				end else if (pick < 75) begin
					range_begin = 9'($urandom_range(1, 511));
					range_end = 9'($urandom_range(0, range_begin - 1));
				end else if (pick < 85) begin
					range_begin = 9'($urandom_range(0, LEAF_COUNT - 1));
					range_end = 9'($urandom_range(LEAF_COUNT + 1, 511));
				end else if (pick < 92) begin
					range_begin = 9'($urandom_range(LEAF_COUNT + 1, 511));
					range_end = 9'($urandom_range(0, 511));
				end else begin
					range_begin = 9'd0;
					range_end = 9'(LEAF_COUNT);
				end
				send_request(OP_QUERY, 8'($urandom), $urandom, range_begin, range_end,
					1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		// Wait for every owed result, then give the block time to show extras.
		while (pending_gcds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d updates and %0d range queries; %0d gcd results compared.",
			updates_sent, queries_sent, results_checked);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result receiver: random stalls, and one long hold-off to back the block up.
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			if (results_checked % 64 == 0)
				receiver_steady = ($urandom_range(0, 2) == 0);
			if (!long_hold_done && results_checked >= 100) begin
				long_hold_done = 1'b1;
				stall = LONG_HOLD;
			end else begin
				stall = receiver_steady ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!(m_tvalid && m_tready));
		end
	end

	// Compare each accepted result with the oldest owed gcd.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (pending_gcds.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("ERROR: t=%0t unexpected result, expected none, got %h",
						$time, m_tdata);
				mismatch_count++;
			end else begin
				oldest_gcd = pending_gcds.pop_front();
				if (m_tdata !== oldest_gcd) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("ERROR: t=%0t gcd_result expected %h, got %h",
							$time, oldest_gcd, m_tdata);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles with %0d results owed",
				cycle_count, pending_gcds.size());
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// ===== files.f =====
rtl/rgcd_seg_pkg.sv
rtl/range_gcd_segment_tree_top.sv
bench/testbench.sv
